// ----- src/tsb_pkg.sv -----
// Shared types, constants and the tanh table for the tilt-shift band blend.
`default_nettype none

package tsb_pkg;

  localparam int ROW_W      = 12;
  localparam int MAX_ROWS   = 4096;
  localparam int OFFSET_W   = 12;
  localparam int HEIGHT_W   = 13;
  localparam int DECAY_W    = 7;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_ADDR_W = 2;

  localparam int BASE_W    = ROW_W + 1;
  localparam int ARG_W     = HEIGHT_W + 2;
  localparam int MAG_W     = ARG_W - 1;
  localparam int FRAC_BITS = 6;
  localparam int NUM_W     = MAG_W + FRAC_BITS;
  localparam int Q_W       = 9;
  localparam int REM_W     = DECAY_W + Q_W - 1;
  localparam int LANES     = 2;

  localparam int DIV_STAGES     = 3;
  localparam int BITS_PER_STAGE = Q_W / DIV_STAGES;
  localparam int ALPHA_STAGES   = DIV_STAGES + 3;

  localparam int TANH_W    = 16;
  localparam int ROM_DEPTH = 257;
  localparam int ALPHA_W   = 17;
  localparam int TS_W      = ALPHA_W + 1;
  localparam int DIFF_W    = TS_W + 1;
  localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);
  localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(0);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(20);
  localparam logic [DECAY_W-1:0]  DECAY_RST  = DECAY_W'(7);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BAND_OFFSET = 2'd0,
    REG_BAND_HEIGHT = 2'd1,
    REG_DECAY       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] band_offset;
    logic [HEIGHT_W-1:0] band_height;
    logic [DECAY_W-1:0]  decay;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] sharp_red;
    logic [PIX_W-1:0] sharp_green;
    logic [PIX_W-1:0] sharp_blue;
    logic [PIX_W-1:0] blurred_red;
    logic [PIX_W-1:0] blurred_green;
    logic [PIX_W-1:0] blurred_blue;
  } pix_t;

  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } lane_t;

  typedef logic [ROM_DEPTH-1:0][TANH_W-1:0] rom_t;

  function automatic rom_t build_tanh_rom();
    rom_t        rom;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] dvd;
    logic [63:0] dvs;
    logic [63:0] quo;
    logic [63:0] rem;
    rom = '0;
    e   = 64'd1 << 30;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      num = ((64'd1 << 30) - e) << 16;
      den = (64'd1 << 30) + e;
      dvd = (num << 1) + den;
      dvs = den << 1;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
        rem = {rem[62:0], dvd[i]};
        if (rem >= dvs) begin
          rem    = rem - dvs;
          quo[i] = 1'b1;
        end
      end
      rom[k] = quo[TANH_W-1:0];
      e = (e * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ----- src/tsb_alpha.sv -----
// Pipelined band weight: row distances, tanh argument division, table lookup and alpha.
`default_nettype none

module tsb_alpha
  import tsb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [ROW_W-1:0]   row,
  input  cfg_t               cfg,
  output logic               alpha_valid,
  output logic [ALPHA_W-1:0] alpha
);

  localparam rom_t TANH_ROM = build_tanh_rom();

  logic [ALPHA_STAGES-1:0] valid;
  logic [DECAY_W-1:0]      dv;

  logic [ROW_W-1:0]         row_c;
  logic signed [BASE_W-1:0] base;
  logic signed [BASE_W-1:0] base_next;
  logic signed [ARG_W-1:0]  far;
  logic signed [ARG_W-1:0]  far_next;

  lane_t lane [DIV_STAGES+1][LANES];
  lane_t prep_next [LANES];
  lane_t lane_next [DIV_STAGES][LANES];

  logic [ALPHA_W-1:0] alpha_next;

  assign dv = (cfg.decay == '0) ? DECAY_W'(1) : cfg.decay;

  always_comb begin
    row_c = (32'(row) >= MAX_ROWS) ? ROW_W'(MAX_ROWS - 1) : row;
    base_next = $signed({1'b0, row_c}) - $signed({1'b0, cfg.band_offset});
    far_next  = $signed({{(ARG_W-BASE_W){base_next[BASE_W-1]}}, base_next})
              - $signed({2'b00, cfg.band_height[HEIGHT_W-1:1], 1'b0});
  end

  always_comb begin
    logic signed [ARG_W-1:0] a;
    logic [MAG_W-1:0]        mag;
    logic [NUM_W-1:0]        num;
    logic [REM_W-1:0]        lim;
    for (int l = 0; l < LANES; l++) begin
      a   = (l == 0) ? $signed({{(ARG_W-BASE_W){base[BASE_W-1]}}, base}) : far;
      mag = a[ARG_W-1] ? MAG_W'(-a) : MAG_W'(a);
      num = {mag, {FRAC_BITS{1'b0}}} + NUM_W'(dv >> 1);
      lim = REM_W'({dv, {(Q_W-1){1'b0}}}) + REM_W'(dv);
      prep_next[l].neg = a[ARG_W-1];
      prep_next[l].sat = num >= NUM_W'(lim);
      prep_next[l].rem = num[REM_W-1:0];
      prep_next[l].q   = '0;
    end
  end

  always_comb begin
    lane_t            t;
    logic [REM_W-1:0] dsh;
    int               b;
    for (int st = 0; st < DIV_STAGES; st++) begin
      for (int l = 0; l < LANES; l++) begin
        t = lane[st][l];
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
          b   = Q_W - 1 - st * BITS_PER_STAGE - j;
          dsh = REM_W'(dv) << b;
          if (t.rem >= dsh) begin
            t.rem  = t.rem - dsh;
            t.q[b] = 1'b1;
          end
        end
        lane_next[st][l] = t;
      end
    end
  end

  always_comb begin
    logic [ALPHA_W-1:0]       mag_t;
    logic signed [TS_W-1:0]   ts [LANES];
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] half;
    for (int l = 0; l < LANES; l++) begin
      mag_t = lane[DIV_STAGES][l].sat ? ONE_Q16
            : {1'b0, TANH_ROM[lane[DIV_STAGES][l].q]};
      ts[l] = lane[DIV_STAGES][l].neg ? -$signed({1'b0, mag_t}) : $signed({1'b0, mag_t});
    end
    diff = DIFF_W'(ts[0]) - DIFF_W'(ts[1]) + DIFF_W'(1);
    half = diff >>> 1;
    if (half < 0) begin
      alpha_next = '0;
    end else if (half > $signed(DIFF_W'(ONE_Q16))) begin
      alpha_next = ONE_Q16;
    end else begin
      alpha_next = half[ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[ALPHA_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    base <= base_next;
    far  <= far_next;
    for (int l = 0; l < LANES; l++) begin
      lane[0][l] <= prep_next[l];
      for (int st = 0; st < DIV_STAGES; st++) begin
        lane[st+1][l] <= lane_next[st][l];
      end
    end
    alpha <= alpha_next;
  end

  assign alpha_valid = valid[ALPHA_STAGES-1];

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    alpha_valid |-> alpha <= ONE_Q16)
    else $error("alpha above one");

  a_far_zero: assert property (@(posedge clk) disable iff (rst)
    valid[ALPHA_STAGES-2] && lane[DIV_STAGES][0].sat && lane[DIV_STAGES][1].sat
      && (lane[DIV_STAGES][0].neg == lane[DIV_STAGES][1].neg) |=> alpha == '0)
    else $error("alpha nonzero far outside band");

  a_empty_band: assert property (@(posedge clk) disable iff (rst)
    alpha_valid && (cfg.band_height[HEIGHT_W-1:1] == '0) |-> alpha == '0)
    else $error("alpha nonzero for empty band");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##(ALPHA_STAGES) alpha_valid)
    else $error("request lost in alpha pipeline");

endmodule

`default_nettype wire

// ----- src/tilt_shift_band_blend.sv -----
// Top level: configuration registers, pixel delay line and per-channel blend stage.
// done is registered from alpha_valid, in step with the registered blend outputs.
// Throughput: one pixel per clock; six stages form alpha (three quotient bits per stage
// in the tanh argument divider) and one stage does the multiply-add blend.
// Reset: rst clears the pipeline valid bits and loads band_offset 0, band_height 20,
// decay 7; busy is high only during reset. done strobes once per result, no stall.
`default_nettype none

module tilt_shift_band_blend
  import tsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [ROW_W-1:0]      row,
  input  logic [PIX_W-1:0]      sharp_red,
  input  logic [PIX_W-1:0]      sharp_green,
  input  logic [PIX_W-1:0]      sharp_blue,
  input  logic [PIX_W-1:0]      blurred_red,
  input  logic [PIX_W-1:0]      blurred_green,
  input  logic [PIX_W-1:0]      blurred_blue,
  output logic                  done,
  output logic [PIX_W-1:0]      out_red,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_blue
);

  localparam int SUM_W = PIX_W + ALPHA_W + 1;

  cfg_t               cfg;
  logic               in_valid;
  logic               alpha_valid;
  logic [ALPHA_W-1:0] alpha;
  pix_t               pix [ALPHA_STAGES];

  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] s,
                                             input logic [PIX_W-1:0] b,
                                             input logic [ALPHA_W-1:0] a);
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-17:0]  v;
    sum = SUM_W'(s * a) + SUM_W'(b * (ONE_Q16 - a)) + SUM_W'(32768);
    v   = sum[SUM_W-1:16];
    return (v > (SUM_W-16)'(255)) ? PIX_W'(255) : v[PIX_W-1:0];
  endfunction

  assign busy     = rst;
  assign in_valid = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_offset <= OFFSET_RST;
      cfg.band_height <= HEIGHT_RST;
      cfg.decay       <= DECAY_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_BAND_OFFSET: cfg.band_offset <= cfg_data[OFFSET_W-1:0];
        REG_BAND_HEIGHT: cfg.band_height <= cfg_data[HEIGHT_W-1:0];
        REG_DECAY:       cfg.decay       <= cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  tsb_alpha u_alpha (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .row         (row),
    .cfg         (cfg),
    .alpha_valid (alpha_valid),
    .alpha       (alpha)
  );

  always_ff @(posedge clk) begin
    pix[0].sharp_red     <= sharp_red;
    pix[0].sharp_green   <= sharp_green;
    pix[0].sharp_blue    <= sharp_blue;
    pix[0].blurred_red   <= blurred_red;
    pix[0].blurred_green <= blurred_green;
    pix[0].blurred_blue  <= blurred_blue;
    for (int i = 1; i < ALPHA_STAGES; i++) begin
      pix[i] <= pix[i-1];
    end
    out_red   <= blend(pix[ALPHA_STAGES-1].sharp_red,
                       pix[ALPHA_STAGES-1].blurred_red, alpha);
    out_green <= blend(pix[ALPHA_STAGES-1].sharp_green,
                       pix[ALPHA_STAGES-1].blurred_green, alpha);
    out_blue  <= blend(pix[ALPHA_STAGES-1].sharp_blue,
                       pix[ALPHA_STAGES-1].blurred_blue, alpha);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= alpha_valid;
    end
  end

endmodule

`default_nettype wire
